// File: hdl/se3cm_pkg.sv
// se3cm_pkg: shared types and constants for the se3 cayley map pipeline
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps

package se3cm_pkg;

    localparam int R_FRAC    = 30;
    localparam int DIV_STEPS = R_FRAC + 1;
    localparam int NLANE     = 9;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_twist;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pose;

    typedef logic [NLANE-1:0][63:0] t_lane64;
    typedef logic [NLANE-1:0][31:0] t_lane32;

    // values that ride along the divider: entry signs and the translation input
    typedef struct packed {
        logic [NLANE-1:0] neg;
        logic [2:0][31:0] y;
    } t_side;

endpackage

// File: hdl/se3cm_if.sv
// se3cm_if: valid/ready channel interfaces for twist input and pose output
// depends on se3cm_pkg
`timescale 1ns / 1ps

interface se3cm_in_if;
    logic              valid;
    logic              ready;
    se3cm_pkg::t_twist data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface se3cm_out_if;
    logic             valid;
    logic             ready;
    se3cm_pkg::t_pose data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/se3cm_div.sv
// se3cm_div: nine-lane pipelined fraction divider, one quotient bit per stage
// depends on se3cm_pkg
`timescale 1ns / 1ps

module se3cm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_den,
    input  se3cm_pkg::t_lane64  i_mag,
    input  se3cm_pkg::t_side    i_side,
    output logic                o_valid,
    output se3cm_pkg::t_lane32  o_q,
    output se3cm_pkg::t_side    o_side
);

    localparam int NST = se3cm_pkg::DIV_STEPS + 1;

    logic [NST-1:0]     r_vld;
    logic [63:0]        r_den  [NST];
    se3cm_pkg::t_lane64 r_rem  [NST];
    se3cm_pkg::t_lane64 n_rem  [NST];
    se3cm_pkg::t_lane32 r_quo  [NST];
    se3cm_pkg::t_lane32 n_quo  [NST];
    se3cm_pkg::t_side   r_side [NST];

    always_comb begin
        logic [63:0] gap;
        gap = '0;
        // first stage: limit to den, integer bit
        for (int l = 0; l < se3cm_pkg::NLANE; l++) begin
            if (i_mag[l] >= i_den) begin
                n_rem[0][l] = '0;
                n_quo[0][l] = 32'd1;
            end else begin
                n_rem[0][l] = i_mag[l];
                n_quo[0][l] = '0;
            end
        end
        // remainder stays below den, so 2r >= den is tested as r >= den - r
        for (int k = 1; k < NST; k++) begin
            for (int l = 0; l < se3cm_pkg::NLANE; l++) begin
                gap = r_den[k-1] - r_rem[k-1][l];
                if (r_rem[k-1][l] >= gap) begin
                    n_rem[k][l] = r_rem[k-1][l] - gap;
                    n_quo[k][l] = {r_quo[k-1][l][30:0], 1'b1};
                end else begin
                    n_rem[k][l] = {r_rem[k-1][l][62:0], 1'b0};
                    n_quo[k][l] = {r_quo[k-1][l][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            r_rem[0]  <= n_rem[0];
            r_quo[0]  <= n_quo[0];
            for (int k = 1; k < NST; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_q     = r_quo[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// File: hdl/se3_cayley_map_top.sv
// se3 cayley map: twist (x, y) to rotation R in Q2.30 and translation t = (I+R)y
// a word passes stages 1-4, the divider, stages 5-7 and the output buffer
// one word per cycle unless held; the 32 one-bit divider stages set the depth
// a two-word output buffer lets input continue while a result waits
// synchronous active-low reset clears all valid bits and the output buffer
`timescale 1ns / 1ps

module se3_cayley_map_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    se3cm_in_if.sink            i_in,
    se3cm_out_if.source         o_out
);

    localparam logic [63:0]        ONE2   = 64'd1 << (2 * FRAC_BITS);
    localparam logic signed [32:0] ONE_R  = 33'sd1 <<< se3cm_pkg::R_FRAC;
    localparam logic [63:0]        HALF_R = 64'd1 << (se3cm_pkg::R_FRAC - 1);

    function automatic logic signed [64:0] skew_term(input logic signed [31:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        return e <<< FRAC_BITS;
    endfunction

    function automatic logic [31:0] sat_round(input logic signed [63:0] acc);
        logic        neg;
        logic [63:0] m;
        logic [63:0] q;
        logic [31:0] res;
        neg = acc[63];
        m   = neg ? (64'd0 - acc) : acc;
        q   = (m + HALF_R) >> se3cm_pkg::R_FRAC;
        if (neg) begin
            res = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
        end else begin
            res = (q >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return res;
    endfunction

    logic w_adv;

    // stage 1: input capture
    logic                r1_vld;
    logic signed [31:0]  r1_x [3];
    logic [2:0][31:0]    r1_y;

    // stage 2: products
    logic                r2_vld;
    logic [63:0]         r2_sq [3];
    logic signed [63:0]  r2_p01, r2_p02, r2_p12;
    logic signed [31:0]  r2_x [3];
    logic [2:0][31:0]    r2_y;

    // stage 3: norm and numerators
    logic                r3_vld;
    logic [63:0]         r3_n;
    logic [63:0]         r3_pos [3];
    logic signed [64:0]  r3_a [6];
    logic [2:0][31:0]    r3_y;

    // stage 4: divider operands
    logic                r4_vld;
    logic [63:0]         r4_den;
    se3cm_pkg::t_lane64  r4_mag;
    se3cm_pkg::t_side    r4_side;
    logic [63:0]         n4_den;
    se3cm_pkg::t_lane64  n4_mag;
    logic [8:0]          n4_neg;

    logic                dv_vld;
    se3cm_pkg::t_lane32  dv_q;
    se3cm_pkg::t_side    dv_side;

    // stage 5: rounded rotation entries
    logic                r5_vld;
    se3cm_pkg::t_lane32  r5_rq;
    logic [2:0][31:0]    r5_y;
    se3cm_pkg::t_lane32  n5_rq;

    // stage 6: translation products
    logic                r6_vld;
    se3cm_pkg::t_lane64  r6_prod;
    se3cm_pkg::t_lane32  r6_rq;
    se3cm_pkg::t_lane64  n6_prod;

    // stage 7: translation sums
    logic                r7_vld;
    logic signed [63:0]  r7_acc [3];
    se3cm_pkg::t_lane32  r7_rq;

    // output buffer
    se3cm_pkg::t_pose    r_sk [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    se3cm_pkg::t_pose    n_pose;
    logic                w_push, w_pop;

    // pipeline holds only when the buffer is full and a word is at its door
    assign w_adv      = (r_cnt != 2'd2) || !r7_vld;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= dv_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_comb begin
        logic signed [64:0] ab;
        logic               ng;
        ab     = '0;
        ng     = 1'b0;
        n4_den = ONE2 + r3_n;
        for (int i = 0; i < 3; i++) begin
            ng               = r3_n > r3_pos[i];
            n4_neg[i*4]      = ng;
            n4_mag[i*4]      = ng ? (r3_n - r3_pos[i]) : (r3_pos[i] - r3_n);
        end
        // off-diagonal lanes 1,2,3,5,6,7 take numerators a[0..5]
        for (int k = 0; k < 6; k++) begin
            ng = r3_a[k][64];
            ab = ng ? (65'sd0 - r3_a[k]) : r3_a[k];
            n4_neg[k + 1 + k / 3] = ng;
            n4_mag[k + 1 + k / 3] = {ab[62:0], 1'b0};
        end
    end

    always_comb begin
        logic [32:0] t;
        t = '0;
        for (int l = 0; l < se3cm_pkg::NLANE; l++) begin
            t        = {1'b0, dv_q[l]} + 33'd1;
            n5_rq[l] = dv_side.neg[l] ? (32'd0 - t[32:1]) : t[32:1];
        end
    end

    always_comb begin
        logic signed [32:0] c;
        logic signed [64:0] p;
        c = '0;
        p = '0;
        for (int l = 0; l < se3cm_pkg::NLANE; l++) begin
            c = 33'($signed(r5_rq[l]));
            if (l % 4 == 0) begin
                c = c + ONE_R;
            end
            p          = c * $signed(r5_y[l % 3]);
            n6_prod[l] = p[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x[0] <= i_in.data.rot_x;
            r1_x[1] <= i_in.data.rot_y;
            r1_x[2] <= i_in.data.rot_z;
            r1_y    <= {i_in.data.trans_z, i_in.data.trans_y, i_in.data.trans_x};

            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 64'(r1_x[i] * r1_x[i]);
            end
            r2_p01 <= 64'(r1_x[0] * r1_x[1]);
            r2_p02 <= 64'(r1_x[0] * r1_x[2]);
            r2_p12 <= 64'(r1_x[1] * r1_x[2]);
            r2_x   <= r1_x;
            r2_y   <= r1_y;

            r3_n <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            for (int i = 0; i < 3; i++) begin
                r3_pos[i] <= ONE2 + {r2_sq[i][62:0], 1'b0};
            end
            r3_a[0] <= 65'(r2_p01) - skew_term(r2_x[2]);
            r3_a[1] <= 65'(r2_p02) + skew_term(r2_x[1]);
            r3_a[2] <= 65'(r2_p01) + skew_term(r2_x[2]);
            r3_a[3] <= 65'(r2_p12) - skew_term(r2_x[0]);
            r3_a[4] <= 65'(r2_p02) - skew_term(r2_x[1]);
            r3_a[5] <= 65'(r2_p12) + skew_term(r2_x[0]);
            r3_y    <= r2_y;

            r4_den       <= n4_den;
            r4_mag       <= n4_mag;
            r4_side.neg  <= n4_neg;
            r4_side.y    <= r3_y;

            r5_rq <= n5_rq;
            r5_y  <= dv_side.y;

            r6_prod <= n6_prod;
            r6_rq   <= r5_rq;

            for (int i = 0; i < 3; i++) begin
                r7_acc[i] <= $signed(r6_prod[i*3]) + $signed(r6_prod[i*3+1])
                           + $signed(r6_prod[i*3+2]);
            end
            r7_rq <= r6_rq;
        end
    end

    se3cm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r4_vld),
        .i_den   (r4_den),
        .i_mag   (r4_mag),
        .i_side  (r4_side),
        .o_valid (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    always_comb begin
        n_pose.r00   = r7_rq[0];
        n_pose.r01   = r7_rq[1];
        n_pose.r02   = r7_rq[2];
        n_pose.r10   = r7_rq[3];
        n_pose.r11   = r7_rq[4];
        n_pose.r12   = r7_rq[5];
        n_pose.r20   = r7_rq[6];
        n_pose.r21   = r7_rq[7];
        n_pose.r22   = r7_rq[8];
        n_pose.pos_x = sat_round(r7_acc[0]);
        n_pose.pos_y = sat_round(r7_acc[1]);
        n_pose.pos_z = sat_round(r7_acc[2]);
    end

    assign w_push = w_adv && r7_vld;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_sk[r_wp] <= n_pose;
        end
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_sk[r_rp];

`ifndef SYNTH
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r1_vld)
        else $error("accepted word did not enter the first stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_cnt == 2'd2) && r7_vld)
        else $error("input held while the output buffer had room");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.data.r00) <= 32'sd1073741824)
                     && ($signed(o_out.data.r00) >= -32'sd1073741824))
        else $error("rotation entry beyond unit magnitude");
`endif

endmodule

// File: tb/tb_se3_cayley_map_top.sv
// testbench for se3_cayley_map_top: random and directed twists with a scoreboard
// depends on se3cm_pkg, se3cm_if and the top level
`timescale 1ns / 1ps

class pose_scoreboard;
    se3cm_pkg::t_pose expected_poses[$];
    int mismatches;
    int checked;

    // round(mag * 2^30 / den), ties away from zero, mag limited to den
    function automatic longint unsigned q30_ratio(longint unsigned mag, longint unsigned den);
        longint unsigned r, q, gap;
        if (mag > den) mag = den;
        q = (mag >= den) ? 64'd1 : 64'd0;
        r = (mag >= den) ? mag - den : mag;
        for (int i = 0; i < se3cm_pkg::R_FRAC + 1; i++) begin
            gap = den - r;
            q = q << 1;
            if (r >= gap) begin
                r = r - gap;
                q = q | 64'd1;
            end else begin
                r = r + r;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic se3cm_pkg::t_pose cayley_pose(se3cm_pkg::t_twist tw, int frac);
        se3cm_pkg::t_pose p;
        longint x[3], y[3], s[3][3], rq[3][3];
        longint unsigned n, one2, den, pos, mag, acc, m;
        longint a, c, q, t;
        logic [31:0] ent[12];
        bit neg;
        x[0] = tw.rot_x; x[1] = tw.rot_y; x[2] = tw.rot_z;
        y[0] = tw.trans_x; y[1] = tw.trans_y; y[2] = tw.trans_z;
        n = 0;
        for (int i = 0; i < 3; i++) n += longint'(x[i] * x[i]);
        one2 = 64'd1 << (2 * frac);
        den = one2 + n;
        s[0][0] = 0;     s[0][1] = -x[2]; s[0][2] = x[1];
        s[1][0] = x[2];  s[1][1] = 0;     s[1][2] = -x[0];
        s[2][0] = -x[1]; s[2][1] = x[0];  s[2][2] = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == j) begin
                    pos = one2 + 2 * longint'(x[i] * x[i]);
                    neg = n > pos;
                    mag = neg ? n - pos : pos - n;
                end else begin
                    a = x[i] * x[j] + s[i][j] * (longint'(1) << frac);
                    neg = a < 0;
                    mag = 2 * (a < 0 ? -a : a);
                end
                q = q30_ratio(mag, den);
                rq[i][j] = neg ? -q : q;
                ent[i * 3 + j] = rq[i][j][31:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                c = rq[i][j] + (i == j ? (longint'(1) << se3cm_pkg::R_FRAC) : 0);
                acc += c * y[j];
            end
            neg = acc[63];
            m = neg ? (~acc + 64'd1) : acc;
            m = (m + (64'd1 << (se3cm_pkg::R_FRAC - 1))) >> se3cm_pkg::R_FRAC;
            if (neg) t = (m >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
            else     t = (m >= 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(m);
            ent[9 + i] = t[31:0];
        end
        p = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5],
             ent[6], ent[7], ent[8], ent[9], ent[10], ent[11]};
        return p;
    endfunction

    function void note_twist(se3cm_pkg::t_twist tw);
        expected_poses.push_back(cayley_pose(tw, 16));
    endfunction

    function void check_pose(se3cm_pkg::t_pose got);
        se3cm_pkg::t_pose exp_p;
        checked++;
        if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose word %h", got);
            return;
        end
        exp_p = expected_poses.pop_front();
        for (int k = 0; k < 12; k++) begin
            if (exp_p[(11 - k) * 32 +: 32] !== got[(11 - k) * 32 +: 32]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pose %0d field %0d: expected %h actual %h", checked, k,
                             exp_p[(11 - k) * 32 +: 32], got[(11 - k) * 32 +: 32]);
            end
        end
    endfunction
endclass

module tb_se3_cayley_map_top;

    localparam int N_RANDOM = 1100;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    se3cm_in_if  twist_ch();
    se3cm_out_if pose_ch();

    pose_scoreboard sb = new();
    int cycles = 0;
    bit quiet = 0;
    int sent = 0;

    se3_cayley_map_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(twist_ch.sink), .o_out(pose_ch.source)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && twist_ch.valid && twist_ch.ready) sb.note_twist(twist_ch.data);
        if (i_rst_n && pose_ch.valid && pose_ch.ready) sb.check_pose(pose_ch.data);
    end

    // output stall in bursts, none near the end
    initial begin
        pose_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                pose_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                pose_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | ($urandom_range(0, 3));
            2: return 32'h7FFF_FFFC | ($urandom_range(0, 3));
            3: return {{16{1'b0}}, 16'h0} + $urandom_range(0, 32'h0001_FFFF)
                      - 32'h0000_FFFF;
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    task automatic send_twist(se3cm_pkg::t_twist tw);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            twist_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        twist_ch.valid <= 1'b1;
        twist_ch.data  <= tw;
        @(posedge i_clk);
        while (!twist_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    initial begin
        se3cm_pkg::t_twist tw;
        logic [31:0] edges[6];
        edges = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF};
        twist_ch.valid = 1'b0;
        twist_ch.data  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: zero, unit axes, extremes, translation saturation
        for (int k = 0; k < 6; k++) begin
            tw = {edges[k], edges[(k + 1) % 6], edges[(k + 2) % 6],
                  edges[(k + 3) % 6], edges[(k + 4) % 6], edges[(k + 5) % 6]};
            send_twist(tw);
            tw = {edges[k], 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
            send_twist(tw);
            tw = {32'h0, 32'h0, edges[k], 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            send_twist(tw);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 150) quiet = 1;
            tw = {rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp()};
            send_twist(tw);
        end
        twist_ch.valid <= 1'b0;
        while (sb.expected_poses.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d twists, checked %0d poses incl. extremes and saturation",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.expected_poses.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: se3_cayley_map_top.f
hdl/se3cm_pkg.sv
hdl/se3cm_if.sv
hdl/se3cm_div.sv
hdl/se3_cayley_map_top.sv
tb/tb_se3_cayley_map_top.sv
